FILE: src/pcf_pkg.sv
// shared types and constants of the pixel color filter
package pcf_pkg;

	localparam int CHAN_W = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;

	// filter modes
	localparam logic [2:0] MODE_NEGATIVE  = 3'd0;
	localparam logic [2:0] MODE_GRAYSCALE = 3'd1;
	localparam logic [2:0] MODE_THRESHOLD = 3'd2;
	localparam logic [2:0] MODE_REPLACE   = 3'd3;
	localparam logic [2:0] MODE_CONTRAST  = 3'd4;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MATCH_COLOR = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NEW_COLOR   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MARGIN      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN        = 3'd4;

	localparam logic [15:0] GAIN_RESET = 16'd256;

	// Q16 luma weights, they sum to 65536
	localparam logic [15:0] W_RED   = 16'd13926;
	localparam logic [15:0] W_GREEN = 16'd46885;
	localparam logic [15:0] W_BLUE  = 16'd4725;

	// D*10000 <= m^2*195075*256 scaled down by 400 on both sides
	localparam logic [14:0] DIST_SCALE  = 15'd25;
	localparam logic [16:0] LIMIT_SCALE = 17'd124848;

	typedef struct packed {
		logic [2:0]  mode;
		logic [23:0] match_color;
		logic [31:0] new_color;
		logic [6:0]  margin_percent;
		logic [15:0] contrast_gain;
	} cfg_t;

	typedef logic [2:0][CHAN_W-1:0] rgb_t;

endpackage

FILE: src/pixel_color_filter_unit.sv
// Pixel color filter: one RGBA pixel in, one filtered pixel out.
// A pixel is taken at every clock edge with start high; busy stays low, so one pixel
// per cycle is sustained with no gaps. The result is on out_* for one cycle with done
// high, in input order; the longest path is the replace distance pipeline (squares,
// weighted products, sum, compare, output select).
// The receiver cannot stall. Registers are written through cfg_we / cfg_index /
// cfg_data and must only change while no pixel is in flight.
module pixel_color_filter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [7:0]                        in_red,
	input  logic [7:0]                        in_green,
	input  logic [7:0]                        in_blue,
	input  logic [7:0]                        in_alpha,
	output logic                              done,
	output logic [7:0]                        out_red,
	output logic [7:0]                        out_green,
	output logic [7:0]                        out_blue,
	output logic [7:0]                        out_alpha,
	input  logic                              cfg_we,
	input  logic [pcf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pcf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pcf_pkg::cfg_t cfg;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic transfer;

	pcf_pkg::rgb_t rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5;
	logic [7:0]    alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5;
	logic [7:0]    gray_s3, gray_s4, gray_s5;
	pcf_pkg::rgb_t con_s3, con_s4, con_s5;
	logic          match_s5;

	pcf_pkg::rgb_t rgb_sel;
	logic [7:0]    alpha_sel;
	logic [7:0]    bw;
	pcf_pkg::rgb_t rgb_s6;
	logic [7:0]    alpha_s6;

	assign busy = 1'b0;
	assign transfer = start && !busy;

	pcf_cfg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= transfer;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		rgb_s1   <= {in_red, in_green, in_blue};
		alpha_s1 <= in_alpha;
		rgb_s2   <= rgb_s1;
		alpha_s2 <= alpha_s1;
		rgb_s3   <= rgb_s2;
		alpha_s3 <= alpha_s2;
		rgb_s4   <= rgb_s3;
		alpha_s4 <= alpha_s3;
		rgb_s5   <= rgb_s4;
		alpha_s5 <= alpha_s4;
		gray_s4  <= gray_s3;
		gray_s5  <= gray_s4;
		con_s4   <= con_s3;
		con_s5   <= con_s4;
	end

	pcf_gray u_gray (
		.clk     (clk),
		.rgb_s1  (rgb_s1),
		.gray_s3 (gray_s3)
	);

	pcf_contrast u_contrast (
		.clk    (clk),
		.gain   (cfg.contrast_gain),
		.rgb_s1 (rgb_s1),
		.rgb_s3 (con_s3)
	);

	pcf_match u_match (
		.clk            (clk),
		.match_color    (cfg.match_color),
		.margin_percent (cfg.margin_percent),
		.rgb_s1         (rgb_s1),
		.match_s5       (match_s5)
	);

	// below mid gray goes black
	assign bw = gray_s5[7] ? 8'd255 : 8'd0;

	always_comb begin
		rgb_sel   = rgb_s5;
		alpha_sel = alpha_s5;
		unique case (cfg.mode)
			pcf_pkg::MODE_NEGATIVE:  rgb_sel = ~rgb_s5;
			pcf_pkg::MODE_GRAYSCALE: rgb_sel = {gray_s5, gray_s5, gray_s5};
			pcf_pkg::MODE_THRESHOLD: rgb_sel = {bw, bw, bw};
			pcf_pkg::MODE_REPLACE: begin
				if (match_s5) begin
					rgb_sel   = cfg.new_color[31:8];
					alpha_sel = cfg.new_color[7:0];
				end
			end
			pcf_pkg::MODE_CONTRAST:  rgb_sel = con_s5;
			default:                 rgb_sel = rgb_s5;
		endcase
	end

	always_ff @(posedge clk) begin
		rgb_s6   <= rgb_sel;
		alpha_s6 <= alpha_sel;
	end

	assign done      = valid_s6;
	assign out_red   = rgb_s6[2];
	assign out_green = rgb_s6[1];
	assign out_blue  = rgb_s6[0];
	assign out_alpha = alpha_s6;

endmodule

FILE: src/pcf_cfg_regs.sv
// configuration register file of the pixel color filter
module pcf_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pcf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pcf_pkg::CFG_DATA_W-1:0]    cfg_data,
	output pcf_pkg::cfg_t                     cfg
);

	pcf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= pcf_pkg::MODE_NEGATIVE;
			cfg_q.match_color    <= '0;
			cfg_q.new_color      <= '0;
			cfg_q.margin_percent <= '0;
			cfg_q.contrast_gain  <= pcf_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcf_pkg::REG_MODE:        cfg_q.mode           <= cfg_data[2:0];
				pcf_pkg::REG_MATCH_COLOR: cfg_q.match_color    <= cfg_data[23:0];
				pcf_pkg::REG_NEW_COLOR:   cfg_q.new_color      <= cfg_data;
				pcf_pkg::REG_MARGIN:      cfg_q.margin_percent <= cfg_data[6:0];
				pcf_pkg::REG_GAIN:        cfg_q.contrast_gain  <= cfg_data[15:0];
				default:                  cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/pcf_gray.sv
// luma pipeline: weighted products, then truncated sum
module pcf_gray (
	input  logic                        clk,
	input  pcf_pkg::rgb_t               rgb_s1,
	output logic [pcf_pkg::CHAN_W-1:0]  gray_s3
);

	logic [23:0] prod_r_s2, prod_g_s2, prod_b_s2;
	logic [23:0] sum;

	always_ff @(posedge clk) begin
		prod_r_s2 <= {8'd0, pcf_pkg::W_RED}   * {16'd0, rgb_s1[2]};
		prod_g_s2 <= {8'd0, pcf_pkg::W_GREEN} * {16'd0, rgb_s1[1]};
		prod_b_s2 <= {8'd0, pcf_pkg::W_BLUE}  * {16'd0, rgb_s1[0]};
	end

	// weights sum to 1.0 in Q16 so this never carries out of 24 bits
	assign sum = prod_r_s2 + prod_g_s2 + prod_b_s2;

	always_ff @(posedge clk) begin
		gray_s3 <= sum[23:16];
	end

endmodule

FILE: src/pcf_contrast.sv
// contrast pipeline: Q8.8 gain around mid gray, floor and clamp
module pcf_contrast (
	input  logic           clk,
	input  logic [15:0]    gain,
	input  pcf_pkg::rgb_t  rgb_s1,
	output pcf_pkg::rgb_t  rgb_s3
);

	logic signed [25:0] prod_s2 [3];
	logic signed [8:0]  diff [3];
	logic signed [17:0] lvl [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = $signed({1'b0, rgb_s1[i]}) - 9'sd128;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s2[i] <= $signed({1'b0, gain}) * diff[i];
		end
	end

	// arithmetic shift gives the floor for negative products too
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lvl[i] = prod_s2[i][25:8] + 18'sd128;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (lvl[i][17]) begin
				rgb_s3[i] <= '0;
			end else if (lvl[i] > 18'sd255) begin
				rgb_s3[i] <= 8'd255;
			end else begin
				rgb_s3[i] <= lvl[i][7:0];
			end
		end
	end

endmodule

FILE: src/pcf_match.sv
// redmean distance pipeline for color replace
module pcf_match (
	input  logic           clk,
	input  logic [23:0]    match_color,
	input  logic [6:0]     margin_percent,
	input  pcf_pkg::rgb_t  rgb_s1,
	output logic           match_s5
);

	logic [7:0]  mr, mg, mb;
	logic [7:0]  dr, dg, db;
	logic [8:0]  rsum;
	logic [7:0]  rm;
	logic [9:0]  wr_coef, wb_coef;

	logic [15:0] dr2_s2, dg2_s2, db2_s2;
	logic [14:0] coef_r_s2, coef_b_s2;
	logic [13:0] msq_s2;

	logic [30:0] wr_s3, wg_s3, wb_s3, lim_s3;
	logic [32:0] d25_s4;
	logic [30:0] lim_s4;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	assign mr = match_color[23:16];
	assign mg = match_color[15:8];
	assign mb = match_color[7:0];

	assign dr = abs_diff(rgb_s1[2], mr);
	assign dg = abs_diff(rgb_s1[1], mg);
	assign db = abs_diff(rgb_s1[0], mb);
	assign rsum = {1'b0, rgb_s1[2]} + {1'b0, mr};
	assign rm = rsum[8:1];
	assign wr_coef = 10'd512 + {2'b0, rm};
	assign wb_coef = 10'd767 - {2'b0, rm};

	always_ff @(posedge clk) begin
		dr2_s2    <= {8'd0, dr} * {8'd0, dr};
		dg2_s2    <= {8'd0, dg} * {8'd0, dg};
		db2_s2    <= {8'd0, db} * {8'd0, db};
		coef_r_s2 <= {5'd0, wr_coef} * pcf_pkg::DIST_SCALE;
		coef_b_s2 <= {5'd0, wb_coef} * pcf_pkg::DIST_SCALE;
		msq_s2    <= {7'd0, margin_percent} * {7'd0, margin_percent};
	end

	// every term already carries the factor 25 of the scaled compare
	always_ff @(posedge clk) begin
		wr_s3  <= {16'd0, coef_r_s2} * {15'd0, dr2_s2};
		wg_s3  <= {15'd0, dg2_s2} * 31'd25600;
		wb_s3  <= {16'd0, coef_b_s2} * {15'd0, db2_s2};
		lim_s3 <= {17'd0, msq_s2} * {14'd0, pcf_pkg::LIMIT_SCALE};
	end

	always_ff @(posedge clk) begin
		d25_s4 <= {2'b0, wr_s3} + {2'b0, wg_s3} + {2'b0, wb_s3};
		lim_s4 <= lim_s3;
	end

	// zero margin matches every pixel
	always_ff @(posedge clk) begin
		match_s5 <= (margin_percent == 7'd0) || (d25_s4 <= {2'b0, lim_s4});
	end

endmodule
